### hdl/yta_pkg.sv
// ----------------------------------------------------------------------------
// yta_pkg - shared types and constants
// Entry format between the unpacking front end and the colour pipeline,
// BT.601 coefficients and the reciprocal used for the divide by 1000.
// ----------------------------------------------------------------------------
package yta_pkg;

	// byte order codes for the mode register
	localparam logic MODE_YUYV = 1'b0;
	localparam logic MODE_UYVY = 1'b1;

	// full-range BT.601 coefficients, scaled by 1000
	localparam logic [10:0] COEF_RV = 11'd1402;
	localparam logic [10:0] COEF_GU = 11'd344;
	localparam logic [10:0] COEF_GV = 11'd714;
	localparam logic [10:0] COEF_BU = 11'd1772;

	// floor(m / 1000) == (m * RECIP_K) >> RECIP_SHIFT for every m < 2**18
	localparam logic [18:0] RECIP_K     = 19'd268436;
	localparam int          RECIP_SHIFT = 28;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [7:0] CHAN_MAX     = 8'hFF;

	// one unpacked macropixel: two luma samples, shared chroma (bias removed)
	typedef struct packed {
		logic [7:0]        y0;
		logic [7:0]        y1;
		logic signed [7:0] u;
		logic signed [7:0] v;
		logic              drop;
	} entry_t;

	// queue status seen by the back end
	typedef struct packed {
		logic   valid;
		entry_t entry;
	} q_head_t;

endpackage

### hdl/yta_front.sv
// ----------------------------------------------------------------------------
// yta_front - mode register and macropixel unpacking
// Holds the byte order register and splits a packed word into Y0, Y1, U, V.
// ----------------------------------------------------------------------------
module yta_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_wdata,
	input  logic [31:0]      macropixel,
	input  logic             drop_second,
	output yta_pkg::entry_t  entry
);

	logic       mode_q;
	logic [7:0] b0, b1, b2, b3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= yta_pkg::MODE_YUYV;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	assign b0 = macropixel[7:0];
	assign b1 = macropixel[15:8];
	assign b2 = macropixel[23:16];
	assign b3 = macropixel[31:24];

	// chroma bias removal: flipping the top bit gives b - 128 in two's complement
	always_comb begin
		entry.drop = drop_second;
		case (mode_q)
			yta_pkg::MODE_UYVY: begin
				entry.u  = $signed(b0 ^ 8'h80);
				entry.y0 = b1;
				entry.v  = $signed(b2 ^ 8'h80);
				entry.y1 = b3;
			end
			default: begin
				entry.y0 = b0;
				entry.u  = $signed(b1 ^ 8'h80);
				entry.y1 = b2;
				entry.v  = $signed(b3 ^ 8'h80);
			end
		endcase
	end

endmodule

### hdl/yta_queue.sv
// ----------------------------------------------------------------------------
// yta_queue - two-entry queue between front end and colour pipeline
// Lets the front end keep accepting while the back end is held.
// ----------------------------------------------------------------------------
module yta_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  yta_pkg::entry_t   push_entry,
	input  logic              pop,
	output logic              full,
	output yta_pkg::q_head_t  head
);

	yta_pkg::entry_t mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;

	assign full       = (count_q == 2'd2);
	assign head.valid = (count_q != 2'd0);
	assign head.entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue written while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("queue read while empty");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with count");

endmodule

### hdl/yta_back.sv
// ----------------------------------------------------------------------------
// yta_back - three-stage colour conversion pipeline
// s1 chroma products, s2 divide by 1000 via reciprocal, s3 sum, clamp, pack.
// ----------------------------------------------------------------------------
module yta_back (
	input  logic              clk,
	input  logic              arst_n,
	input  yta_pkg::q_head_t  head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [31:0]       first_pixel,
	output logic [31:0]       second_pixel,
	output logic              second_valid
);

	logic adv;

	// stage 1
	logic        v_s1;
	logic [7:0]  y0_s1, y1_s1;
	logic        drop_s1, un_s1, vn_s1;
	logic [18:0] p_rv_s1, p_gu_s1, p_gv_s1, p_bu_s1;
	logic [7:0]  u_mag, v_mag;

	// stage 2
	logic        v_s2;
	logic [7:0]  y0_s2, y1_s2;
	logic        drop_s2;
	logic signed [8:0] t_rv_s2, t_gu_s2, t_gv_s2, t_bu_s2;
	logic [37:0] m_rv, m_gu, m_gv, m_bu;
	logic [7:0]  q_rv, q_gu, q_gv, q_bu;

	// stage 3 (output register)
	logic        v_s3;
	logic [31:0] px0_s3, px1_s3;
	logic        sv_s3;
	logic [31:0] px0, px1;

	assign adv = !(v_s3 && out_stall);
	assign pop = head.valid && adv;

	assign u_mag = head.entry.u[7] ? 8'(-head.entry.u) : 8'(head.entry.u);
	assign v_mag = head.entry.v[7] ? 8'(-head.entry.v) : 8'(head.entry.v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			y0_s1   <= head.entry.y0;
			y1_s1   <= head.entry.y1;
			drop_s1 <= head.entry.drop;
			un_s1   <= head.entry.u[7];
			vn_s1   <= head.entry.v[7];
			p_rv_s1 <= 19'(v_mag * yta_pkg::COEF_RV);
			p_gu_s1 <= 19'(u_mag * yta_pkg::COEF_GU);
			p_gv_s1 <= 19'(v_mag * yta_pkg::COEF_GV);
			p_bu_s1 <= 19'(u_mag * yta_pkg::COEF_BU);
		end
	end

	// magnitude quotient, then sign back on: truncation toward zero
	assign m_rv = 38'(p_rv_s1) * 38'(yta_pkg::RECIP_K);
	assign m_gu = 38'(p_gu_s1) * 38'(yta_pkg::RECIP_K);
	assign m_gv = 38'(p_gv_s1) * 38'(yta_pkg::RECIP_K);
	assign m_bu = 38'(p_bu_s1) * 38'(yta_pkg::RECIP_K);
	assign q_rv = m_rv[yta_pkg::RECIP_SHIFT +: 8];
	assign q_gu = m_gu[yta_pkg::RECIP_SHIFT +: 8];
	assign q_gv = m_gv[yta_pkg::RECIP_SHIFT +: 8];
	assign q_bu = m_bu[yta_pkg::RECIP_SHIFT +: 8];

	always_ff @(posedge clk) begin
		if (adv) begin
			y0_s2   <= y0_s1;
			y1_s2   <= y1_s1;
			drop_s2 <= drop_s1;
			t_rv_s2 <= vn_s1 ? -$signed({1'b0, q_rv}) : $signed({1'b0, q_rv});
			t_gu_s2 <= un_s1 ? -$signed({1'b0, q_gu}) : $signed({1'b0, q_gu});
			t_gv_s2 <= vn_s1 ? -$signed({1'b0, q_gv}) : $signed({1'b0, q_gv});
			t_bu_s2 <= un_s1 ? -$signed({1'b0, q_bu}) : $signed({1'b0, q_bu});
		end
	end

	function automatic logic [7:0] clamp(input logic signed [10:0] x);
		logic [7:0] res;
		if (x < 0) begin
			res = 8'd0;
		end else if (x > 11'sd255) begin
			res = yta_pkg::CHAN_MAX;
		end else begin
			res = x[7:0];
		end
		return res;
	endfunction

	function automatic logic [31:0] make_px(input logic [7:0] y,
		input logic signed [8:0] trv, input logic signed [8:0] tgu,
		input logic signed [8:0] tgv, input logic signed [8:0] tbu);
		logic signed [10:0] ys, r, g, b;
		ys = $signed({3'b000, y});
		r  = ys + 11'(trv);
		g  = ys - 11'(tgu) - 11'(tgv);
		b  = ys + 11'(tbu);
		return {yta_pkg::ALPHA_OPAQUE, clamp(r), clamp(g), clamp(b)};
	endfunction

	assign px0 = make_px(y0_s2, t_rv_s2, t_gu_s2, t_gv_s2, t_bu_s2);
	assign px1 = make_px(y1_s2, t_rv_s2, t_gu_s2, t_gv_s2, t_bu_s2);

	always_ff @(posedge clk) begin
		if (adv) begin
			px0_s3 <= px0;
			px1_s3 <= drop_s2 ? 32'd0 : px1;
			sv_s3  <= !drop_s2;
		end
	end

	assign out_valid    = v_s3;
	assign first_pixel  = px0_s3;
	assign second_pixel = px1_s3;
	assign second_valid = sv_s3;

	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !second_valid) |-> (second_pixel == 32'd0))
		else $error("dropped second pixel not zero");

	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (first_pixel[31:24] == yta_pkg::ALPHA_OPAQUE))
		else $error("first pixel alpha not opaque");

	a_pop_flow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> v_s1)
		else $error("popped item lost at stage 1");

endmodule

### hdl/yuv422_packed_to_argb.sv
// ----------------------------------------------------------------------------
// yuv422_packed_to_argb - packed 4:2:2 macropixel to two ARGB32 pixels
// Full-range BT.601 conversion of YUYV or UYVY words, one item per clock unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel: in_valid / in_stall with macropixel (first memory byte in
//    bits 7:0) and drop_second, set on the last item of an odd-width row.
//  - Output channel: out_valid / out_stall with first_pixel, second_pixel and
//    second_valid. Alpha is always 0xFF; a dropped second pixel reads as 0.
//  - cfg_we / cfg_wdata write the byte order: 0 YUYV, 1 UYVY. Write it only
//    while no item is in flight.
//  - Path: an accepted item is written into the queue, then passes the
//    three-stage pipeline, whose last stage is the output register.
//  - Throughput: one item per clock while the receiver does not stall, set by
//    the fully pipelined colour path.
//  - When the receiver stalls, the pipeline holds; the two-entry queue keeps
//    taking items until full, then in_stall rises.
//  - Reset clears the queue, all stage valids and selects YUYV order.
// ----------------------------------------------------------------------------
module yuv422_packed_to_argb (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] macropixel,
	input  logic        drop_second,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] first_pixel,
	output logic [31:0] second_pixel,
	output logic        second_valid
);

	yta_pkg::entry_t  entry;
	yta_pkg::q_head_t head;
	logic             q_full;
	logic             push;
	logic             pop;

	// front end: byte order register and unpacking
	yta_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.macropixel  (macropixel),
		.drop_second (drop_second),
		.entry       (entry)
	);

	// an item is taken whenever the queue has room
	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	yta_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (entry),
		.pop        (pop),
		.full       (q_full),
		.head       (head)
	);

	// back end: colour maths and output register
	yta_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.first_pixel  (first_pixel),
		.second_pixel (second_pixel),
		.second_valid (second_valid)
	);

endmodule

### dv/yuv422_packed_to_argb_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// yuv422_packed_to_argb_tb - self-checking bench for the 4:2:2 to ARGB32 block
// Drives YUYV and UYVY macropixels with random gaps and output back-pressure.
// A scoreboard works out the expected pixel pair for every accepted item and
// checks the results in order.
// ----------------------------------------------------------------------------
module yuv422_packed_to_argb_tb;

	// expected output of one item
	typedef struct {
		logic [31:0] first;
		logic [31:0] second;
		logic        second_ok;
	} argb_pair_t;

	// ------------------------------------------------------------------------
	// Scoreboard: own copy of the byte order, BT.601 predictor, result queue
	// ------------------------------------------------------------------------
	class pixel_scoreboard;
		localparam int K_RV  = 1402;
		localparam int K_GU  = 344;
		localparam int K_GV  = 714;
		localparam int K_BU  = 1772;
		localparam int K_DIV = 1000;
		localparam int BIAS  = 128;

		logic       order;
		argb_pair_t pending_pixels[$];
		int         errors;

		function new();
			order  = yta_pkg::MODE_YUYV;
			errors = 0;
		endfunction

		function int pending();
			return pending_pixels.size();
		endfunction

		function logic [7:0] sat8(int x);
			if (x < 0)
				return 8'd0;
			if (x > 255)
				return 8'd255;
			return x[7:0];
		endfunction

		// SV integer divide truncates toward zero, which is what is wanted
		function logic [31:0] bt601_pixel(int y, int u, int v);
			int r, g, b;
			r = y + (K_RV * v) / K_DIV;
			g = y - (K_GU * u) / K_DIV - (K_GV * v) / K_DIV;
			b = y + (K_BU * u) / K_DIV;
			return {yta_pkg::ALPHA_OPAQUE, sat8(r), sat8(g), sat8(b)};
		endfunction

		function void note_item(logic [31:0] word, logic drop);
			int         b0, b1, b2, b3;
			int         y0, y1, u, v;
			argb_pair_t e;
			b0 = word[7:0];
			b1 = word[15:8];
			b2 = word[23:16];
			b3 = word[31:24];
			if (order == yta_pkg::MODE_YUYV) begin
				y0 = b0; u = b1 - BIAS; y1 = b2; v = b3 - BIAS;
			end else begin
				u = b0 - BIAS; y0 = b1; v = b2 - BIAS; y1 = b3;
			end
			e.first = bt601_pixel(y0, u, v);
			if (drop) begin
				e.second    = 32'd0;
				e.second_ok = 1'b0;
			end else begin
				e.second    = bt601_pixel(y1, u, v);
				e.second_ok = 1'b1;
			end
			pending_pixels.push_back(e);
		endfunction

		task report(string msg);
			$display("%0t ns: MISMATCH %s", $time, msg);
			errors++;
		endtask

		task check_result(logic [31:0] first, logic [31:0] second, logic second_ok);
			argb_pair_t e;
			if (pending_pixels.size() == 0) begin
				report($sformatf("result %h %h %b with nothing expected",
					first, second, second_ok));
			end else begin
				e = pending_pixels.pop_front();
				if (first !== e.first)
					report($sformatf("first_pixel %h, expected %h", first, e.first));
				if (second !== e.second)
					report($sformatf("second_pixel %h, expected %h", second, e.second));
				if (second_ok !== e.second_ok)
					report($sformatf("second_valid %b, expected %b",
						second_ok, e.second_ok));
			end
		endtask
	endclass

	// ------------------------------------------------------------------------
	// DUT signals and instance
	// ------------------------------------------------------------------------
	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] macropixel;
	logic        drop_second;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] first_pixel;
	logic [31:0] second_pixel;
	logic        second_valid;

	pixel_scoreboard sb;
	logic            idle_on;	// random gaps and stalls allowed
	logic            cur_order;	// byte order the stimulus is packed for

	yuv422_packed_to_argb uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.macropixel   (macropixel),
		.drop_second  (drop_second),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.first_pixel  (first_pixel),
		.second_pixel (second_pixel),
		.second_valid (second_valid)
	);

	// 20 ns clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Monitor: sees pre-edge values, so it samples exactly what the DUT took.
	// Register writes update the scoreboard's order copy at the same edge.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.order = cfg_wdata;
			if (in_valid && !in_stall)
				sb.note_item(macropixel, drop_second);
			if (out_valid && !out_stall)
				sb.check_result(first_pixel, second_pixel, second_valid);
		end
	end

	// Receiver back-pressure: random bursts of stalled cycles while idling is on
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// byte biased towards the ends of the range and the chroma zero point
	function automatic logic [7:0] edge_byte();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'h01;
			2:       return 8'h7F;
			3:       return 8'h80;
			4:       return 8'h81;
			5:       return 8'hFE;
			6:       return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// random macropixel; some items push luma or chroma to the extremes
	function automatic logic [31:0] random_word(logic order);
		logic [7:0] y0, y1, cb, cr;
		int         kind;
		kind = $urandom_range(0, 3);
		y0 = (kind == 2) ? edge_byte() : 8'($urandom);
		y1 = (kind == 2) ? edge_byte() : 8'($urandom);
		cb = (kind == 1) ? edge_byte() : 8'($urandom);
		cr = (kind == 1) ? edge_byte() : 8'($urandom);
		if (kind == 3)
			return $urandom;
		if (order == yta_pkg::MODE_YUYV)
			return {cr, y1, cb, y0};
		return {y1, cr, y0, cb};
	endfunction

	// Drive one item and hold it until accepted; may leave a gap afterwards.
	// Called right after a rising edge.
	task automatic send_item(logic [31:0] word, logic drop);
		in_valid    <= 1'b1;
		macropixel  <= word;
		drop_second <= drop;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	// stop sending and wait for every expected result to come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// byte order may only change with nothing in flight
	task automatic set_order(logic order);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= order;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_order = order;
	endtask

	task automatic run_random(int count);
		for (int i = 0; i < count; i++)
			send_item(random_word(cur_order), $urandom_range(0, 3) == 0);
	endtask

	// corner words: all zero, all ones, neutral chroma, chroma at both
	// extremes against black and white luma, plus a few mixed patterns
	logic [31:0] corner_words [12] = '{
		32'h00000000, 32'hFFFFFFFF, 32'h80808080, 32'h80008000,
		32'h00FF00FF, 32'hFF00FF00, 32'hFFFF0000, 32'h00FFFF00,
		32'h7F817F81, 32'h81FF7F00, 32'hA5A55A5A, 32'h12345678
	};

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		sb          = new();
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = yta_pkg::MODE_YUYV;
		in_valid    = 1'b0;
		macropixel  = 32'd0;
		drop_second = 1'b0;
		idle_on     = 1'b1;
		cur_order   = yta_pkg::MODE_YUYV;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: the reset order first, then the same words as UYVY,
		// with the dropped second pixel on every third item
		for (int i = 0; i < 12; i++)
			send_item(corner_words[i], (i % 3) == 1);
		set_order(yta_pkg::MODE_UYVY);
		for (int i = 0; i < 12; i++)
			send_item(corner_words[i], (i % 3) == 1);

		// random part, flipping the order between phases
		set_order(yta_pkg::MODE_YUYV);
		run_random(250);
		set_order(yta_pkg::MODE_UYVY);
		run_random(250);
		set_order(yta_pkg::MODE_YUYV);
		run_random(250);
		set_order(yta_pkg::MODE_UYVY);
		run_random(250);
		set_order(yta_pkg::MODE_YUYV);
		run_random(250);

		// last phase at full rate, no gaps and no stalls
		set_order(yta_pkg::MODE_UYVY);
		idle_on = 1'b0;
		run_random(250);

		drain();
		repeat (6) @(posedge clk);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
